// ===== rtl/core/mmrc_pkg.sv =====
// Shared types and constants for the Modbus meter reply checker.
package mmrc_pkg;

  localparam int unsigned MAX_FRAME_DEF = 40;
  localparam int unsigned COUNT_W       = 6;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 6'd63;
  localparam logic [COUNT_W-1:0] MIN_LAST_POS = 6'd14;  // position of byte 15
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  ADDR_RESET = 8'h01;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_ADDR = 2'd1,
    STAT_BAD_CRC  = 2'd2,
    STAT_BAD_LEN  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] voltage;
    logic [31:0] current;
    logic [31:0] power;
  } result_t;

endpackage

// ===== rtl/core/modbus_meter_reply_checker.sv =====
// Top level of the Modbus RTU meter reply checker.
// The block takes one reply byte per cycle, with the final byte of a frame marked by
// in_frame_end, and gives one report per frame: a status (ok, wrong address, CRC mismatch,
// bad length) and the voltage, current and power words of the last good frame. A byte
// moves from the input register through the combinational CRC-16 byte step and frame checks
// into the result register, so a frame's report is registered in the result register after
// its final byte has passed the input register, and a new byte can be accepted every
// cycle while the result register can take the report. The expected slave address is
// written through cfg_wr_en and resets to 1.
module modbus_meter_reply_checker import mmrc_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_voltage_value,
  output logic [31:0] out_current_value,
  output logic [31:0] out_power_value
);

  byte_item_t in_item, item;
  logic       item_valid, item_ready;
  logic       res_valid, res_ready;
  result_t    res, out_res;

  assign in_item.data = in_rx_byte;
  assign in_item.last = in_frame_end;

  mmrc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item)
  );

  mmrc_frame #(
    .MAX_FRAME(MAX_FRAME)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  mmrc_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_status        = out_res.status;
  assign out_voltage_value = out_res.voltage;
  assign out_current_value = out_res.current;
  assign out_power_value   = out_res.power;

endmodule

// ===== rtl/core/mmrc_in_reg.sv =====
// Input register stage that holds one received byte for the frame checker.
module mmrc_in_reg import mmrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  byte_item_t in_item,
  output logic       item_valid,
  input  logic       item_ready,
  output byte_item_t item
);

  logic       valid_r;
  byte_item_t item_r;

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/core/mmrc_frame.sv =====
// Per-frame state: address check, trailing CRC-16/Modbus, word assembly and held values.
module mmrc_frame import mmrc_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  byte_item_t item,
  input  logic       res_ready,
  output logic       res_valid,
  output result_t    res
);

  function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [7:0]         addr_r;
  logic [15:0]        crc_r, crc_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]         dly0_r, dly0_nxt, dly1_r, dly1_nxt;
  logic               addr_ok_r, addr_ok_nxt;
  logic [31:0]        pend_r [3];
  logic [31:0]        pend_nxt [3];
  logic [31:0]        held_r [3];
  logic [31:0]        held_nxt [3];

  logic               take;
  logic [COUNT_W-1:0] pos_m3;
  logic [15:0]        crc_fed;
  status_t            status;

  assign item_ready = !item.last || res_ready;
  assign take       = item_valid && item_ready;
  assign pos_m3     = count_r - COUNT_W'(3);

  always_comb begin
    addr_ok_nxt = addr_ok_r;
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    dly0_nxt    = dly0_r;
    dly1_nxt    = dly1_r;
    pend_nxt    = pend_r;
    held_nxt    = held_r;
    status      = STAT_OK;

    if (count_r == '0) begin
      addr_ok_nxt = (item.data == addr_r);
    end
    if (count_r >= COUNT_W'(3) && count_r <= MIN_LAST_POS) begin
      case (pos_m3[3:2])
        2'd0:    pend_nxt[0] = {pend_r[0][23:0], item.data};
        2'd1:    pend_nxt[1] = {pend_r[1][23:0], item.data};
        2'd2:    pend_nxt[2] = {pend_r[2][23:0], item.data};
        default: ;
      endcase
    end
    // The CRC trails the byte stream by two so the last two bytes stay out of it.
    crc_fed = (count_r >= COUNT_W'(2)) ? crc_feed(crc_r, dly1_r) : crc_r;

    if (!item.last) begin
      crc_nxt  = crc_fed;
      dly1_nxt = dly0_r;
      dly0_nxt = item.data;
      if (count_r < COUNT_SAT) begin
        count_nxt = count_r + COUNT_W'(1);
      end
    end else begin
      if (count_r < MIN_LAST_POS || count_r >= COUNT_W'(MAX_FRAME)) begin
        status = STAT_BAD_LEN;
      end else if (!addr_ok_nxt) begin
        status = STAT_BAD_ADDR;
      end else if (crc_fed[7:0] != dly0_r || crc_fed[15:8] != item.data) begin
        status = STAT_BAD_CRC;
      end else begin
        status = STAT_OK;
      end
      if (status == STAT_OK) begin
        held_nxt = pend_nxt;
      end
      crc_nxt     = CRC_INIT;
      count_nxt   = '0;
      dly0_nxt    = '0;
      dly1_nxt    = '0;
      addr_ok_nxt = 1'b0;
      for (int i = 0; i < 3; i++) begin
        pend_nxt[i] = '0;
      end
    end
  end

  assign res_valid   = take && item.last;
  assign res.status  = status;
  assign res.voltage = held_nxt[0];
  assign res.current = held_nxt[1];
  assign res.power   = held_nxt[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= ADDR_RESET;
      crc_r     <= CRC_INIT;
      count_r   <= '0;
      dly0_r    <= '0;
      dly1_r    <= '0;
      addr_ok_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pend_r[i] <= '0;
        held_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        addr_r <= cfg_wr_data;
      end
      if (take) begin
        crc_r     <= crc_nxt;
        count_r   <= count_nxt;
        dly0_r    <= dly0_nxt;
        dly1_r    <= dly1_nxt;
        addr_ok_r <= addr_ok_nxt;
        pend_r    <= pend_nxt;
        held_r    <= held_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/mmrc_out_reg.sv =====
// Result register that holds one frame report until it is taken.
module mmrc_out_reg import mmrc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  output logic    res_ready,
  input  result_t res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule
